// ----- sv/bounded_stack_with_search_assert.svh -----
// assertion macros for the stack block
`ifndef BOUNDED_STACK_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_STACK_WITH_SEARCH_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BSWS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BSWS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bsws_pkg.sv -----
`timescale 1ns / 1ps

package bsws_pkg;

  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_POP    = 3'd1;
  localparam logic [2:0] CMD_PEEK   = 3'd2;
  localparam logic [2:0] CMD_SEARCH = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_MISS  = 2'd3;

  typedef enum logic [2:0] {
    C_HOLD,
    C_PUSH,
    C_POP,
    C_MARK,
    C_SCAN
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] key;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic signed [31:0] word_out;
    logic [1:0]         status;
    logic [9:0]         found_pos;
    logic [10:0]        fill_count;
    logic               is_empty;
  } result_t;

endpackage

// ----- sv/bounded_stack_with_search.sv -----
// push, pop, peek, clear and unused codes: the result is queued at the input beat
// search: all cells compare at the input beat, then the hit flags shift toward
// the top one cell per cycle; the result is queued when a hit reaches cell 0, or as
// a miss at the deepest held entry; a search holds the input until its result is queued
// other commands are taken every cycle while the two-entry output queue has room
// synchronous active-high reset empties the stack and the output queue; entries keep data
`timescale 1ns / 1ps
`include "bounded_stack_with_search_assert.svh"

module bounded_stack_with_search #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] word_out,
  output logic [1:0]         status,
  output logic [9:0]         found_pos,
  output logic [10:0]        fill_count,
  output logic               is_empty
);
  import bsws_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);  // count width, holds DEPTH itself
  localparam int SW = $clog2(DEPTH);      // scan position width

  // control state
  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [SW-1:0] scan_cnt, scan_next;

  // cell chain, cell 0 holds the top of stack
  logic signed [31:0] cell_data [DEPTH];
  logic               cell_hit  [DEPTH];
  logic               cell_live [DEPTH];
  cell_ctrl_t         ctrl;

  // result path
  result_t res;
  logic    res_push;
  result_t head;
  logic    skid_valid;

  logic fire;
  logic full;
  logic empty;
  logic last_scan;

  assign fire      = in_valid && in_ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  // next shift would move past the deepest held entry
  assign last_scan = ((CW'(scan_cnt) + CW'(1)) >= count);

  // only one command at a time, and never while the skid slot is taken
  assign in_ready = (state == S_IDLE) && !skid_valid;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [31:0] up_data;
      logic signed [31:0] dn_data;
      logic               dn_hit;

      // a cell only matches if it holds a live entry
      assign cell_live[gi] = (CW'(gi) < count);

      if (gi == 0) begin : g_top
        assign up_data = operand;
      end else begin : g_mid
        assign up_data = cell_data[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_bot
        assign dn_data = cell_data[gi];
        assign dn_hit  = 1'b0;
      end else begin : g_inner
        assign dn_data = cell_data[gi+1];
        assign dn_hit  = cell_hit[gi+1];
      end

      bsws_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .live    (cell_live[gi]),
        .up_data (up_data),
        .dn_data (dn_data),
        .dn_hit  (dn_hit),
        .data    (cell_data[gi]),
        .hit     (cell_hit[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      scan_cnt <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_cnt <= scan_next;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    scan_next      = scan_cnt;
    ctrl.op        = C_HOLD;
    ctrl.key       = operand;
    res_push       = 1'b0;
    res.word_out   = '0;
    res.status     = STAT_OK;
    res.found_pos  = '0;
    res.fill_count = 11'(count);
    res.is_empty   = empty;
    case (state)
      S_IDLE: begin
        if (fire) begin
          res_push = 1'b1;
          case (cmd)
            CMD_PUSH: begin
              if (full) begin
                res.status = STAT_FULL;  // value dropped
              end else begin
                ctrl.op    = C_PUSH;
                count_next = count + CW'(1);
              end
            end
            CMD_POP: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else begin
                ctrl.op      = C_POP;
                res.word_out = cell_data[0];
                count_next   = count - CW'(1);
              end
            end
            CMD_PEEK: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else begin
                res.word_out = cell_data[0];
              end
            end
            CMD_SEARCH: begin
              // every cell compares now, the result comes from the scan
              ctrl.op    = C_MARK;
              res_push   = 1'b0;
              scan_next  = '0;
              state_next = S_SCAN;
            end
            CMD_CLEAR: begin
              count_next = '0;
            end
            default: ;  // unused codes leave the stack alone
          endcase
          res.fill_count = 11'(count_next);
          res.is_empty   = (count_next == '0);
        end
      end
      S_SCAN: begin
        if (cell_hit[0]) begin
          res_push      = 1'b1;
          res.found_pos = 10'(scan_cnt);
          state_next    = S_IDLE;
        end else if (last_scan) begin
          res_push   = 1'b1;
          res.status = STAT_MISS;
          state_next = S_IDLE;
        end else begin
          // hit flags move one cell toward the top
          ctrl.op   = C_SCAN;
          scan_next = scan_cnt + SW'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  bsws_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (res_push),
    .push_res   (res),
    .pop        (out_valid && out_ready),
    .head_valid (out_valid),
    .head       (head),
    .skid_valid (skid_valid)
  );

  assign word_out   = head.word_out;
  assign status     = head.status;
  assign found_pos  = head.found_pos;
  assign fill_count = head.fill_count;
  assign is_empty   = head.is_empty;

  // count stays within the chain
  `BSWS_ASSERT_IMP(a_count_range, 1'b1, count <= CW'(DEPTH), "count beyond depth")
  // the scan never walks past the held entries
  `BSWS_ASSERT_IMP(a_scan_range, state == S_SCAN, CW'(scan_cnt) <= count, "scan past count")
  // any command other than search leaves a result valid at the output on the next cycle
  `BSWS_ASSERT_NXT(a_quick_result, fire && (cmd != CMD_SEARCH), out_valid, "missing result")
  // a search always enters the scan
  `BSWS_ASSERT_NXT(a_search_scan, fire && (cmd == CMD_SEARCH), state == S_SCAN, "no scan")

endmodule

// ----- sv/bsws_cell.sv -----
`timescale 1ns / 1ps

module bsws_cell (
  input  logic                clk,
  input  bsws_pkg::cell_ctrl_t ctrl,
  input  logic                live,
  input  logic signed [31:0]  up_data,
  input  logic signed [31:0]  dn_data,
  input  logic                dn_hit,
  output logic signed [31:0]  data,
  output logic                hit
);
  import bsws_pkg::*;

  logic signed [31:0] data_next;
  logic               hit_next;

  always_comb begin
    data_next = data;
    hit_next  = hit;
    case (ctrl.op)
      C_PUSH:  data_next = up_data;
      C_POP:   data_next = dn_data;
      C_MARK:  hit_next  = live && (data == ctrl.key);
      C_SCAN:  hit_next  = dn_hit;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    hit  <= hit_next;
  end

endmodule

// ----- sv/bsws_outq.sv -----
`timescale 1ns / 1ps

module bsws_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bsws_pkg::result_t push_res,
  input  logic              pop,
  output logic              head_valid,
  output bsws_pkg::result_t head,
  output logic              skid_valid
);
  import bsws_pkg::*;

  result_t skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop && skid_valid) begin
      head       <= skid;
      skid_valid <= push;
      if (push) begin
        skid <= push_res;
      end
    end else if (pop) begin
      head_valid <= push;
      if (push) begin
        head <= push_res;
      end
    end else if (push) begin
      if (!head_valid) begin
        head       <= push_res;
        head_valid <= 1'b1;
      end else begin
        skid       <= push_res;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

// ----- test/bounded_stack_with_search_test.sv -----
`timescale 1ns / 1ps

module bounded_stack_with_search_test;
  import bsws_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int TOTAL_BEATS = 600;
  // spare command codes past clear, ignored by the block
  localparam logic [2:0] CMD_SPARE_FIRST = CMD_CLEAR + 3'd1;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_ALL_ONES = -32'sd1;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [2:0] cmd;
  logic signed [31:0] operand;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] word_out;
  logic [1:0] status;
  logic [9:0] found_pos;
  logic [10:0] fill_count;
  logic is_empty;

  // shadow of the stack: takes each accepted command beat, queues the result it must give
  class stack_tracker;
    logic signed [31:0] cells [STACK_DEPTH];
    int held;
    result_t awaited_results[$];
    int errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    function void take_command(logic [2:0] op, logic signed [31:0] arg);
      result_t r;
      r = '0;
      case (op)
        CMD_PUSH: begin
          if (held >= STACK_DEPTH) r.status = STAT_FULL;
          else begin
            cells[held] = arg;
            held++;
          end
        end
        CMD_POP: begin
          if (held == 0) r.status = STAT_EMPTY;
          else begin
            held--;
            r.word_out = cells[held];
          end
        end
        CMD_PEEK: begin
          if (held == 0) r.status = STAT_EMPTY;
          else r.word_out = cells[held - 1];
        end
        CMD_SEARCH: begin
          // nearest hit from the top wins
          r.status = STAT_MISS;
          for (int i = held - 1; i >= 0; i--) begin
            if (cells[i] == arg) begin
              r.status = STAT_OK;
              r.found_pos = 10'(held - 1 - i);
              break;
            end
          end
        end
        CMD_CLEAR: held = 0;
        default: ;
      endcase
      r.fill_count = 11'(held);
      r.is_empty = (held == 0);
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual word %0d status %0d count %0d",
                 $time, got.word_out, got.status, got.fill_count);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("word_out", want.word_out, got.word_out);
      compare_field("status", want.status, got.status);
      compare_field("found_pos", want.found_pos, got.found_pos);
      compare_field("fill_count", want.fill_count, got.fill_count);
      compare_field("is_empty", want.is_empty, got.is_empty);
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction
  endclass

  stack_tracker tracker = new();

  // steady and hold_off are shared between the sender and the receiver process
  bit steady;
  int hold_off;
  int beats_sent;
  logic signed [31:0] value_pool [8];

  bounded_stack_with_search #(
    .DEPTH(STACK_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .operand(operand),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .word_out(word_out),
    .status(status),
    .found_pos(found_pos),
    .fill_count(fill_count),
    .is_empty(is_empty)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // both handshakes are sampled at the rising edge, inputs move at the falling edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.take_command(cmd, operand);
      if (out_valid && out_ready)
        tracker.match_result({word_out, status, found_pos, fill_count, is_empty});
    end
  end

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] pick_value();
    // a small pool makes duplicates and search hits common
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic logic [2:0] random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) return CMD_PUSH;
    if (r < 58) return CMD_POP;
    if (r < 68) return CMD_PEEK;
    if (r < 92) return CMD_SEARCH;
    if (r < 96) return CMD_CLEAR;
    return CMD_SPARE_FIRST + 3'($urandom_range(0, 2));
  endfunction

  // one command beat; valid stays high afterwards so back-to-back beats need no dip
  task automatic offer_command(input logic [2:0] op, input logic signed [31:0] arg);
    int gap;
    gap = steady ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = op;
    operand = arg;
    do @(posedge clk); while (!in_ready);
    if (op <= CMD_CLEAR) beats_sent++;
  endtask

  // sender goes quiet, then every queued result has to come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  // receiver: random stalls, or a long hold-off when the sender asks for one
  initial begin
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready = 1'b0;
        repeat (hold_off - 1) @(negedge clk);
        hold_off = 0;
      end else if (steady || $urandom_range(0, 3) != 0) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        repeat (idle_len()) @(negedge clk);
      end
    end
  end

  initial begin
    int pick;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_PUSH;
    operand = '0;
    steady = 1'b0;
    hold_off = 0;
    beats_sent = 0;
    value_pool[0] = WORD_MIN;
    value_pool[1] = WORD_MAX;
    value_pool[2] = '0;
    value_pool[3] = WORD_ALL_ONES;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // empty stack: pop and peek flag empty, search misses
    offer_command(CMD_POP, $urandom());
    offer_command(CMD_PEEK, $urandom());
    offer_command(CMD_SEARCH, '0);
    // extremes, with a duplicate so the nearest hit matters
    offer_command(CMD_PUSH, WORD_MAX);
    offer_command(CMD_PUSH, WORD_MIN);
    offer_command(CMD_PUSH, '0);
    offer_command(CMD_PUSH, WORD_ALL_ONES);
    offer_command(CMD_PUSH, WORD_MIN);
    offer_command(CMD_PEEK, $urandom());
    offer_command(CMD_SEARCH, WORD_MIN);
    offer_command(CMD_SEARCH, WORD_MAX);
    offer_command(CMD_SEARCH, WORD_ALL_ONES);
    offer_command(CMD_SEARCH, 32'sd12345);
    // spare codes leave the stack alone
    offer_command(CMD_SPARE_FIRST, $urandom());
    offer_command(CMD_SPARE_FIRST + 3'd1, $urandom());
    offer_command(CMD_SPARE_FIRST + 3'd2, $urandom());
    offer_command(CMD_POP, $urandom());
    offer_command(CMD_POP, $urandom());
    offer_command(CMD_PEEK, $urandom());
    // clear keeps the old data but nothing below the count is searchable
    offer_command(CMD_CLEAR, $urandom());
    offer_command(CMD_POP, $urandom());
    offer_command(CMD_SEARCH, WORD_MAX);

    // long receiver hold-off while beats keep coming, so the input side backs up
    wait_for_results();
    steady = 1'b1;
    hold_off = 150;
    repeat (24) offer_command(random_cmd(), pick_value());
    steady = 1'b0;
    wait_for_results();

    // random part: fill runs to overflow, drain runs to underflow, mixed runs
    while (beats_sent < TOTAL_BEATS) begin
      steady = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        repeat (STACK_DEPTH + 2) offer_command(CMD_PUSH, pick_value());
      end else if (pick < 28) begin
        repeat (STACK_DEPTH + 2) offer_command(CMD_POP, $urandom());
      end else if (pick < 32) begin
        wait_for_results();
      end else begin
        repeat ($urandom_range(8, 30)) offer_command(random_cmd(), pick_value());
      end
    end
    steady = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;

    wait_for_results();
    // a search on a full stack is the slowest command; leave room for stray beats
    repeat (3 * STACK_DEPTH) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("bounded_stack_with_search_test: PASS");
    end else begin
      $display("bounded_stack_with_search_test: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("bounded_stack_with_search_test: FAIL");
    $finish;
  end

endmodule
